// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// clocked assertion that also runs during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== rtl/mtfbc_pkg.sv =====
// shared types and constants of the move-to-front block cache
// no dependencies
package mtfbc_pkg;

  localparam int KEY_W    = 64;
  localparam int OFF_W    = 48;
  localparam int HANDLE_W = 16;
  localparam int SIZE_W   = 4;

  typedef enum logic {
    MODE_LOOKUP = 1'b0,
    MODE_INSERT = 1'b1
  } mode_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key_high;
    logic [KEY_W-1:0]    key_low;
    logic [OFF_W-1:0]    blk_offset;
    logic [HANDLE_W-1:0] buffer_handle;
    logic                occupied;
  } slot_t;

  typedef struct packed {
    logic              capture;
    logic              commit;
    logic              insert;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] limit;
  } cell_ctrl_t;

endpackage

// ===== rtl/mtfbc_ifs.sv =====
// channel interfaces: request, response and configuration write
// depends on mtfbc_pkg
interface mtfbc_req_if;
  import mtfbc_pkg::*;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [KEY_W-1:0]    key_high;
  logic [KEY_W-1:0]    key_low;
  logic [OFF_W-1:0]    blk_offset;
  logic [HANDLE_W-1:0] buffer_handle;

  modport source (output valid, mode, key_high, key_low, blk_offset, buffer_handle,
                  input ready);
  modport sink (input valid, mode, key_high, key_low, blk_offset, buffer_handle,
                output ready);
endinterface

interface mtfbc_rsp_if;
  import mtfbc_pkg::*;
  logic                valid;
  logic                ready;
  logic                hit;
  logic [HANDLE_W-1:0] found_handle;
  logic                evicted_valid;
  logic [HANDLE_W-1:0] evicted_handle;

  modport source (output valid, hit, found_handle, evicted_valid, evicted_handle,
                  input ready);
  modport sink (input valid, hit, found_handle, evicted_valid, evicted_handle,
                output ready);
endinterface

interface mtfbc_cfg_if;
  import mtfbc_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/mtfbc_cell.sv =====
// one cache slot: holds an entry, compares it, shifts from its front neighbor
// depends on mtfbc_pkg
module mtfbc_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  mtfbc_pkg::cell_ctrl_t ctrl,
  input  mtfbc_pkg::slot_t   cmp_key,
  input  logic               hit_any,
  input  mtfbc_pkg::slot_t   prev_slot,
  input  logic               before_in,
  input  mtfbc_pkg::slot_t   sel_in,
  output mtfbc_pkg::slot_t   slot_q,
  output logic               before_out,
  output mtfbc_pkg::slot_t   sel_out
);
  import mtfbc_pkg::*;

  logic [KEY_W-1:0]    key_high_q;
  logic [KEY_W-1:0]    key_low_q;
  logic [OFF_W-1:0]    offset_q;
  logic [HANDLE_W-1:0] handle_q;
  logic                occupied;
  logic                match;
  logic                in_range;
  logic                key_eq;
  logic                first;
  logic                pick;
  logic                shift;
  logic                load;

  assign slot_q = '{key_high: key_high_q, key_low: key_low_q, blk_offset: offset_q,
                    buffer_handle: handle_q, occupied: occupied};

  // compare against the incoming key, only inside the searched range
  assign in_range = 32'(IDX) < 32'(ctrl.limit);
  assign key_eq   = (key_high_q == cmp_key.key_high) && (key_low_q == cmp_key.key_low) &&
                    (offset_q == cmp_key.blk_offset);

  // front-first priority chain
  assign before_out = before_in | match;
  assign first      = match & ~before_in;

  // pick the hit entry on lookup, the last configured slot on insert
  always_comb begin
    if (ctrl.insert) begin
      pick  = (32'(IDX) + 32'd1) == 32'(ctrl.size);
      shift = 32'(IDX) < 32'(ctrl.size);
    end else begin
      pick  = first;
      shift = hit_any & ~before_in;
    end
  end

  assign sel_out = pick ? slot_t'(sel_in | slot_q) : sel_in;
  assign load    = ctrl.commit & shift;

  // control bits
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
      match    <= 1'b0;
    end else begin
      if (ctrl.capture) begin
        match <= in_range && occupied && key_eq;
      end
      if (load) begin
        occupied <= prev_slot.occupied;
      end
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (load) begin
      key_high_q <= prev_slot.key_high;
      key_low_q  <= prev_slot.key_low;
      offset_q   <= prev_slot.blk_offset;
      handle_q   <= prev_slot.buffer_handle;
    end
  end

endmodule

// ===== rtl/move_to_front_block_cache_core.sv =====
// Move-to-front block cache: a row of slot cells, slot 0 most recent.
// An accepted item is compared into the match flags, then committed, once the result register is free.
// A new item is taken only after the last one has committed; the commit runs the priority and
// select chain through all CACHE_DEPTH cells.
// Reset: synchronous; clears occupied bits, used count and size.
module move_to_front_block_cache_core #(
  parameter int CACHE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  mtfbc_cfg_if.sink   cfg,
  mtfbc_req_if.sink   req,
  mtfbc_rsp_if.source rsp
);
  import mtfbc_pkg::*;

  logic              busy;
  logic [SIZE_W-1:0] active_entries;
  logic [SIZE_W-1:0] used_count;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] limit;
  slot_t             req_q;
  logic              req_insert;
  logic              accept;
  logic              commit;
  slot_t             cmp_key;
  slot_t             front;
  cell_ctrl_t        ctrl;
  logic              hit_any;

  logic                rsp_valid;
  logic                hit_q;
  logic [HANDLE_W-1:0] found_q;
  logic                evicted_valid_q;
  logic [HANDLE_W-1:0] evicted_q;

  logic  before_c [0:CACHE_DEPTH];
  slot_t sel_c    [0:CACHE_DEPTH];
  slot_t slot_c   [0:CACHE_DEPTH-1];

  // configuration write, always taken
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= '0;
    end else if (cfg.valid) begin
      active_entries <= cfg.data;
    end
  end

  // effective size and search limit
  always_comb begin
    if (32'(active_entries) > 32'(CACHE_DEPTH)) begin
      size = SIZE_W'(CACHE_DEPTH);
    end else begin
      size = active_entries;
    end
    limit = (used_count < size) ? used_count : size;
  end

  // handshake
  assign req.ready = ~busy;
  assign accept    = req.valid & ~busy;
  assign commit    = busy & (~rsp_valid | rsp.ready);

  assign cmp_key = '{key_high: req.key_high, key_low: req.key_low,
                     blk_offset: req.blk_offset, buffer_handle: req.buffer_handle,
                     occupied: 1'b1};

  assign ctrl = '{capture: accept, commit: commit, insert: req_insert,
                  size: size, limit: limit};

  // cell chain
  assign before_c[0] = 1'b0;
  assign sel_c[0]    = '0;
  assign hit_any     = before_c[CACHE_DEPTH];
  assign front       = req_insert ? req_q : sel_c[CACHE_DEPTH];

  for (genvar i = 0; i < CACHE_DEPTH; i++) begin : g_cell
    mtfbc_cell #(.IDX(i)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .cmp_key    (cmp_key),
      .hit_any    (hit_any),
      .prev_slot  ((i == 0) ? front : slot_c[(i == 0) ? 0 : i - 1]),
      .before_in  (before_c[i]),
      .sel_in     (sel_c[i]),
      .slot_q     (slot_c[i]),
      .before_out (before_c[i+1]),
      .sel_out    (sel_c[i+1])
    );
  end

  // request capture and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      used_count <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (commit) begin
        busy <= 1'b0;
        if (req_insert && (used_count < size)) begin
          used_count <= used_count + SIZE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q      <= cmp_key;
      req_insert <= (req.mode == MODE_INSERT);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (req_insert) begin
        hit_q   <= 1'b0;
        found_q <= '0;
        if ((size != '0) && sel_c[CACHE_DEPTH].occupied) begin
          evicted_valid_q <= 1'b1;
          evicted_q       <= sel_c[CACHE_DEPTH].buffer_handle;
        end else begin
          evicted_valid_q <= 1'b0;
          evicted_q       <= '0;
        end
      end else begin
        hit_q           <= hit_any;
        found_q         <= hit_any ? sel_c[CACHE_DEPTH].buffer_handle : '0;
        evicted_valid_q <= 1'b0;
        evicted_q       <= '0;
      end
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.hit            = hit_q;
  assign rsp.found_handle   = found_q;
  assign rsp.evicted_valid  = evicted_valid_q;
  assign rsp.evicted_handle = evicted_q;

endmodule

// ===== rtl/mtfbc_checker.sv =====
// port-level checks of the move-to-front block cache, bound to the top level
// depends on mtfbc_pkg and assert_macros.svh
`include "assert_macros.svh"

module mtfbc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic                            rsp_hit,
  input logic [mtfbc_pkg::HANDLE_W-1:0]  rsp_found_handle,
  input logic                            rsp_evicted_valid,
  input logic [mtfbc_pkg::HANDLE_W-1:0]  rsp_evicted_handle
);
  import mtfbc_pkg::*;

  logic [2*HANDLE_W+1:0] rsp_fields;

  // all result fields in one vector
  assign rsp_fields = {rsp_hit, rsp_found_handle, rsp_evicted_valid, rsp_evicted_handle};

  // after reset nothing is pending and a new item can enter
  `ASSERT_CLK_ALWAYS(a_reset_idle, clk, rst |=> !rsp_valid && req_ready)

  // an accepted item occupies the block, so ready drops after the accept
  `ASSERT_CLK(a_busy_after_accept, clk, rst, req_valid && req_ready |=> !req_ready)

  // a new result only follows a cycle in which an item was in flight
  `ASSERT_CLK(a_result_from_item, clk, rst, $rose(rsp_valid) |-> $past(!req_ready))

  // a stalled result holds
  `ASSERT_CLK(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fields))

endmodule

bind move_to_front_block_cache_core mtfbc_checker u_mtfbc_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_hit            (rsp.hit),
  .rsp_found_handle   (rsp.found_handle),
  .rsp_evicted_valid  (rsp.evicted_valid),
  .rsp_evicted_handle (rsp.evicted_handle)
);

// ===== bench/tb_top.sv =====
// self-checking bench for the move-to-front block cache core
// predicts each response from its own copy of the slot row and checks in order
// depends on mtfbc_pkg, the channel interfaces and move_to_front_block_cache_core
module tb_top;
  import mtfbc_pkg::*;

  localparam int DEPTH       = 8;
  localparam int POOL        = 12;
  localparam int SEG_ITEMS   = 155;
  localparam int NUM_SEGS    = 12;
  localparam int STALL_LEN   = 300;
  localparam int IDLE_LIMIT  = 2000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    mode_t               mode;
    logic [KEY_W-1:0]    key_high;
    logic [KEY_W-1:0]    key_low;
    logic [OFF_W-1:0]    blk_offset;
    logic [HANDLE_W-1:0] buffer_handle;
  } req_item_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] found_handle;
    logic                evicted_valid;
    logic [HANDLE_W-1:0] evicted_handle;
  } rsp_item_t;

  logic clk;
  logic rst;

  mtfbc_cfg_if cfg_ch();
  mtfbc_req_if req_ch();
  mtfbc_rsp_if rsp_ch();

  move_to_front_block_cache_core #(.CACHE_DEPTH(DEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow copy of the cache
  slot_t             cache_lines [DEPTH] = '{default: '0};
  int                lines_used = 0;
  logic [SIZE_W-1:0] shadow_size = '0;

  // traffic bookkeeping
  req_item_t req_backlog [$];
  rsp_item_t replies_due [$];
  int        items_pushed   = 0;
  int        items_accepted = 0;
  int        fail_count     = 0;
  int        send_idle_pct  = 0;
  int        recv_idle_pct  = 0;
  int        stall_requests = 0;
  bit        req_fire       = 1'b0;

  // key pool, so lookups find entries that were inserted
  logic [KEY_W-1:0] pool_kh  [POOL];
  logic [KEY_W-1:0] pool_kl  [POOL];
  logic [OFF_W-1:0] pool_off [POOL];

  int seg_sizes [NUM_SEGS] = '{8, 3, 15, 1, 0, 5, 9, 2, 6, 4, 8, 7};

  // lookup with move-to-front or insert at front, updates the shadow cache
  function automatic rsp_item_t mtf_cache_access(input req_item_t it);
    rsp_item_t r;
    slot_t     moved;
    int        size;
    int        lim;
    int        hit_at;
    int        i;
    r = '0;
    size = (shadow_size > DEPTH) ? DEPTH : int'(shadow_size);
    if (it.mode == MODE_LOOKUP) begin
      lim = (lines_used < size) ? lines_used : size;
      hit_at = -1;
      for (i = 0; i < lim; i++) begin
        if (hit_at < 0 && cache_lines[i].key_high == it.key_high &&
            cache_lines[i].key_low == it.key_low &&
            cache_lines[i].blk_offset == it.blk_offset)
          hit_at = i;
      end
      if (hit_at >= 0) begin
        moved = cache_lines[hit_at];
        for (i = hit_at; i > 0; i--) cache_lines[i] = cache_lines[i-1];
        cache_lines[0] = moved;
        r.hit = 1'b1;
        r.found_handle = moved.buffer_handle;
      end
    end else if (size != 0) begin
      if (cache_lines[size-1].occupied) begin
        r.evicted_valid = 1'b1;
        r.evicted_handle = cache_lines[size-1].buffer_handle;
      end
      for (i = size - 1; i > 0; i--) cache_lines[i] = cache_lines[i-1];
      cache_lines[0] = '{key_high: it.key_high, key_low: it.key_low,
                         blk_offset: it.blk_offset,
                         buffer_handle: it.buffer_handle, occupied: 1'b1};
      if (lines_used < size) lines_used++;
    end
    return r;
  endfunction

  // free-running clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // request driver, fed from the backlog
  always @(negedge clk) begin : req_driver
    req_item_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.mode <= 1'b0;
      req_ch.key_high <= '0;
      req_ch.key_low <= '0;
      req_ch.blk_offset <= '0;
      req_ch.buffer_handle <= '0;
    end else if (!req_ch.valid || req_fire) begin
      if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = req_backlog.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.mode <= nxt.mode;
        req_ch.key_high <= nxt.key_high;
        req_ch.key_low <= nxt.key_low;
        req_ch.blk_offset <= nxt.blk_offset;
        req_ch.buffer_handle <= nxt.buffer_handle;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // response ready, with random idling and long hold-offs on request
  always @(negedge clk) begin : rsp_receiver
    int stall_left;
    int stall_served;
    if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (stall_served != stall_requests) begin
      stall_served++;
      stall_left = STALL_LEN;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: predict on each accepted item, check each accepted response
  always @(posedge clk) begin : monitor
    req_item_t it;
    rsp_item_t got;
    rsp_item_t want;
    if (rst) begin
      req_fire = 1'b0;
    end else begin
      req_fire = req_ch.valid && req_ch.ready;
      if (req_fire) begin
        it.mode = mode_t'(req_ch.mode);
        it.key_high = req_ch.key_high;
        it.key_low = req_ch.key_low;
        it.blk_offset = req_ch.blk_offset;
        it.buffer_handle = req_ch.buffer_handle;
        replies_due.push_back(mtf_cache_access(it));
        items_accepted++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{hit: rsp_ch.hit, found_handle: rsp_ch.found_handle,
                evicted_valid: rsp_ch.evicted_valid,
                evicted_handle: rsp_ch.evicted_handle};
        if (replies_due.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected response: hit=%0b found=%h ev=%0b evh=%h",
                     got.hit, got.found_handle, got.evicted_valid, got.evicted_handle);
        end else begin
          want = replies_due.pop_front();
          if (got.hit !== want.hit || got.found_handle !== want.found_handle ||
              got.evicted_valid !== want.evicted_valid ||
              got.evicted_handle !== want.evicted_handle) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display({"mismatch: exp hit=%0b found=%h ev=%0b evh=%h,",
                        " got hit=%0b found=%h ev=%0b evh=%h"},
                       want.hit, want.found_handle, want.evicted_valid, want.evicted_handle,
                       got.hit, got.found_handle, got.evicted_valid, got.evicted_handle);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("FAIL move_to_front_block_cache_core");
        $finish;
      end
    end
  end

  task automatic push_item(input mode_t m, input logic [KEY_W-1:0] kh,
                           input logic [KEY_W-1:0] kl, input logic [OFF_W-1:0] off,
                           input logic [HANDLE_W-1:0] hdl);
    req_backlog.push_back('{mode: m, key_high: kh, key_low: kl,
                            blk_offset: off, buffer_handle: hdl});
    items_pushed++;
  endtask

  // sender pause: everything accepted and every response back
  task automatic wait_drained();
    do @(negedge clk);
    while (items_accepted != items_pushed || replies_due.size() != 0);
  endtask

  // size register write, only while the cache is idle
  task automatic write_size(input logic [SIZE_W-1:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk);
    while (!(cfg_ch.valid && cfg_ch.ready));
    shadow_size = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic refill_pool();
    int k;
    for (k = 0; k < POOL; k++) begin
      pool_kh[k] = {$urandom, $urandom};
      pool_kl[k] = {$urandom, $urandom};
      pool_off[k] = OFF_W'({$urandom, $urandom});
    end
  endtask

  // mostly pool keys so hits and moves happen, some near misses and noise
  task automatic push_random(input int count);
    req_item_t it;
    int        n;
    int        pick;
    int        sel;
    int        pos;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, POOL - 1);
      it.mode = ($urandom_range(0, 99) < 45) ? MODE_INSERT : MODE_LOOKUP;
      it.key_high = pool_kh[pick];
      it.key_low = pool_kl[pick];
      it.blk_offset = pool_off[pick];
      it.buffer_handle = HANDLE_W'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        it.key_high = {$urandom, $urandom};
        it.key_low = {$urandom, $urandom};
        it.blk_offset = OFF_W'({$urandom, $urandom});
      end else if (sel < 27 && it.mode == MODE_LOOKUP) begin
        // one bit off in one key field
        pos = $urandom_range(0, 2);
        case (pos)
          0: it.key_high[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
          1: it.key_low[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
          default: it.blk_offset[$urandom_range(0, OFF_W - 1)] ^= 1'b1;
        endcase
      end
      push_item(it.mode, it.key_high, it.key_low, it.blk_offset, it.buffer_handle);
    end
  endtask

  // stimulus
  initial begin : stimulus
    int i;
    int seg;
    logic [KEY_W-1:0] ones_k;
    logic [OFF_W-1:0] ones_o;
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    ones_k = '1;
    ones_o = '1;
    refill_pool();
    send_idle_pct = 10;
    recv_idle_pct = 63;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // caching disabled: insert changes nothing, lookup misses
    write_size(4'd0);
    push_item(MODE_INSERT, pool_kh[0], pool_kl[0], pool_off[0], 16'h1111);
    push_item(MODE_LOOKUP, pool_kh[0], pool_kl[0], pool_off[0], 16'h0);
    wait_drained();

    // two slots: eviction of an occupied last slot, move-to-front, miss
    write_size(4'd2);
    for (i = 1; i <= 3; i++)
      push_item(MODE_INSERT, pool_kh[i], pool_kl[i], pool_off[i], HANDLE_W'(16'h0101 * i));
    push_item(MODE_LOOKUP, pool_kh[2], pool_kl[2], pool_off[2], 16'hffff);
    push_item(MODE_LOOKUP, pool_kh[1], pool_kl[1], pool_off[1], 16'h0);
    wait_drained();

    // size above depth, field extremes, near misses, duplicate insert
    write_size(4'd15);
    push_item(MODE_INSERT, ones_k, ones_k, ones_o, 16'hffff);
    push_item(MODE_INSERT, '0, '0, '0, 16'h0000);
    push_item(MODE_LOOKUP, '0, '0, '0, 16'hffff);
    push_item(MODE_LOOKUP, ones_k, ones_k, ones_o, 16'h0);
    push_item(MODE_LOOKUP, ones_k, ones_k, ones_o ^ 48'h1, 16'h0);
    push_item(MODE_LOOKUP, ones_k, ones_k ^ (64'h1 << 63), ones_o, 16'h0);
    push_item(MODE_LOOKUP, ones_k ^ 64'h1, ones_k, ones_o, 16'h0);
    push_item(MODE_INSERT, pool_kh[2], pool_kl[2], pool_off[2], 16'h2222);
    push_item(MODE_LOOKUP, pool_kh[2], pool_kl[2], pool_off[2], 16'h0);
    for (i = 4; i <= 8; i++)
      push_item(MODE_INSERT, pool_kh[i], pool_kl[i], pool_off[i], HANDLE_W'($urandom));
    wait_drained();

    // size reduced: deep slots kept but out of reach
    write_size(4'd3);
    push_item(MODE_LOOKUP, ones_k, ones_k, ones_o, 16'h0);
    push_item(MODE_LOOKUP, pool_kh[8], pool_kl[8], pool_off[8], 16'h0);
    wait_drained();

    // random segments, one size setting each, three idling patterns
    for (seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg / 4)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      refill_pool();
      write_size(SIZE_W'(seg_sizes[seg]));
      push_random(SEG_ITEMS / 2);
      // long receiver hold-off while requests keep coming
      if (seg == 1 || seg == 9) stall_requests++;
      wait_drained();
      push_random(SEG_ITEMS - SEG_ITEMS / 2);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && replies_due.size() == 0) begin
      $display("PASS move_to_front_block_cache_core");
    end else begin
      $display("FAIL move_to_front_block_cache_core");
    end
    $finish;
  end

endmodule
